// ===== rtl/core/idp_pkg.sv =====
package idp_pkg;

    localparam int unsigned PENDING_DEPTH_DEF = 32;
    localparam int unsigned STATS_DEPTH_DEF   = 32;

    localparam logic [1:0] CMD_ENTRY  = 2'd0;
    localparam logic [1:0] CMD_EXIT   = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    localparam logic [1:0] REG_WIN_START = 2'd0;
    localparam logic [1:0] REG_WIN_END   = 2'd1;
    localparam logic [1:0] REG_WIN_WIDTH = 2'd2;

    localparam logic [63:0] WIN_END_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] WIN_WIDTH_RST = 64'd1000000000;
    localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  cpu_num;
        logic [9:0]  irq_num;
        logic [63:0] event_time_ns;
    } item_t;

    typedef struct packed {
        logic [7:0]  row_cpu;
        logic [9:0]  row_irq;
        logic [31:0] freq_hz;
        logic [63:0] total_ns;
        logic        dropped;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  cpu;
        logic [9:0]  irq;
        logic [63:0] t;
    } pend_t;

    typedef struct packed {
        logic [9:0]  irq;
        logic [7:0]  cpu;
        logic [31:0] hits;
        logic [63:0] total;
    } stat_t;

endpackage

// ===== rtl/core/idp_ram.sv =====
module idp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/idp_freq_div.sv =====
module idp_freq_div
    import idp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] hits,
    input  logic [63:0] width_ns,
    output logic        done,
    output logic [31:0] freq
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MUL  = 5'b00010,
        D_CHK  = 5'b00100,
        D_ITER = 5'b01000,
        D_DONE = 5'b10000
    } dstate_t;

    dstate_t     state_reg, state_next;
    logic [31:0] hits_reg, hits_next;
    logic [63:0] den_reg, den_next;
    logic [61:0] num_reg, num_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[31]};
    assign done  = (state_reg == D_DONE);
    assign freq  = quo_reg;

    always_comb
    begin
        state_next = state_reg;
        hits_next  = hits_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    hits_next  = hits;
                    den_next   = width_ns;
                    state_next = D_MUL;
                end
            end
            D_MUL:
            begin
                num_next   = hits_reg * NS_PER_SEC;
                state_next = D_CHK;
            end
            D_CHK:
            begin
                // quotient needs more than 32 bits when the upper part reaches the divisor
                if (den_reg == 64'd0 || {34'd0, num_reg[61:32]} >= den_reg)
                begin
                    quo_next   = '1;
                    state_next = D_DONE;
                end
                else
                begin
                    rem_next   = {34'd0, num_reg[61:32]};
                    quo_next   = num_reg[31:0];
                    cnt_next   = '0;
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 64'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[63:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = 5'(cnt_reg + 5'd1);
                if (cnt_reg == 5'd31)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hits_reg <= hits_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

endmodule

// ===== rtl/core/irq_duration_profiler_unit.sv =====
// channel   | direction | signals                            | transaction when
// ----------+-----------+------------------------------------+---------------------
// command   | in        | start, busy, item                  | start && !busy
// result    | out       | result_strobe, result              | result_strobe
// config    | in        | cfg_valid, cfg_ready, cfg_index,   | cfg_valid && cfg_ready
//           |           | cfg_data                           |
//
// entry events and ignored events are taken without leaving the idle state; an exit scans
// the pending entries for its cpu and the statistics rows for its irq, writes the row and
// shifts later pending entries down, each step waiting on a one-read-port memory
// a report reads each row and runs it through the bit-serial frequency divider
// reset is asynchronous and active low; it clears counts and the drop flag, no sweep
// results appear for one cycle each and cannot be stalled by the receiver
module irq_duration_profiler_unit
    import idp_pkg::*;
#(
    parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int unsigned STATS_DEPTH   = STATS_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        result_strobe,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned SAW = (STATS_DEPTH > 1) ? $clog2(STATS_DEPTH) : 1;
    localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned SCW = $clog2(STATS_DEPTH + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_PRD  = 12'b000000000010,
        S_PCHK = 12'b000000000100,
        S_SRD  = 12'b000000001000,
        S_SCHK = 12'b000000010000,
        S_SNEW = 12'b000000100000,
        S_SWR  = 12'b000001000000,
        S_SHR  = 12'b000010000000,
        S_SHW  = 12'b000100000000,
        S_RRD  = 12'b001000000000,
        S_RDAT = 12'b010000000000,
        S_RDIV = 12'b100000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] win_start_reg, win_end_reg, win_width_reg;
    logic [PCW-1:0] pcnt_reg, pcnt_next, pidx_reg, pidx_next;
    logic [SCW-1:0] scnt_reg, scnt_next, sidx_reg, sidx_next;
    logic        drop_reg, drop_next, drop_snap_reg, drop_snap_next;
    logic [7:0]  cpu_reg, cpu_next;
    logic [63:0] time_reg, time_next;
    logic [9:0]  pirq_reg, pirq_next;
    logic [7:0]  pcpu_reg, pcpu_next;
    logic [63:0] dur_reg, dur_next;
    logic [SAW-1:0] row_reg, row_next;
    logic [7:0]  rcpu_reg, rcpu_next;
    logic [31:0] hits_reg, hits_next;
    logic [63:0] total_reg, total_next;
    logic        strobe_reg, strobe_next;
    result_t     result_reg, result_next;

    logic        accept, in_window;
    logic [PCW:0] pidx_p1, pidx_p2;
    logic [SCW:0] sidx_p1;

    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    pend_t          p_wdata, p_rdata;
    logic           s_we;
    stat_t          s_wdata, s_rdata;

    logic        div_start, div_done;
    logic [31:0] div_freq;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_window = (item.event_time_ns > win_start_reg)
                    && (item.event_time_ns < win_end_reg);
    assign pidx_p1   = {1'b0, pidx_reg} + (PCW+1)'(1);
    assign pidx_p2   = {1'b0, pidx_reg} + (PCW+1)'(2);
    assign sidx_p1   = {1'b0, sidx_reg} + (SCW+1)'(1);

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    idp_ram #(.WIDTH($bits(pend_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    idp_ram #(.WIDTH($bits(stat_t)), .DEPTH(STATS_DEPTH)) u_stat_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (row_reg),
        .wdata (s_wdata),
        .raddr (sidx_reg[SAW-1:0]),
        .rdata (s_rdata)
    );

    // the divider latches the row's hit count straight from the memory read
    idp_freq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .hits     (s_rdata.hits),
        .width_ns (win_width_reg),
        .done     (div_done),
        .freq     (div_freq)
    );

    always_comb
    begin
        state_next     = state_reg;
        pcnt_next      = pcnt_reg;
        pidx_next      = pidx_reg;
        scnt_next      = scnt_reg;
        sidx_next      = sidx_reg;
        drop_next      = drop_reg;
        drop_snap_next = drop_snap_reg;
        cpu_next       = cpu_reg;
        time_next      = time_reg;
        pirq_next      = pirq_reg;
        pcpu_next      = pcpu_reg;
        dur_next       = dur_reg;
        row_next       = row_reg;
        rcpu_next      = rcpu_reg;
        hits_next      = hits_reg;
        total_next     = total_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        p_we           = 1'b0;
        p_waddr        = pcnt_reg[PAW-1:0];
        p_wdata        = '{cpu: item.cpu_num, irq: item.irq_num, t: item.event_time_ns};
        p_raddr        = pidx_reg[PAW-1:0];
        s_we           = 1'b0;
        s_wdata        = '{irq: pirq_reg, cpu: rcpu_reg,
                           hits: (hits_reg == 32'hFFFF_FFFF) ? hits_reg
                                                             : 32'(hits_reg + 32'd1),
                           total: 64'(total_reg + dur_reg)};
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cpu_next  = item.cpu_num;
                    time_next = item.event_time_ns;
                    case (item.cmd)
                        CMD_ENTRY:
                        begin
                            if (in_window)
                            begin
                                if (pcnt_reg == PCW'(PENDING_DEPTH))
                                begin
                                    drop_next = 1'b1;
                                end
                                else
                                begin
                                    p_we      = 1'b1;
                                    pcnt_next = PCW'(pcnt_reg + PCW'(1));
                                end
                            end
                        end
                        CMD_EXIT:
                        begin
                            if (in_window && pcnt_reg != '0)
                            begin
                                pidx_next  = '0;
                                state_next = S_PRD;
                            end
                        end
                        CMD_REPORT:
                        begin
                            drop_snap_next = drop_reg;
                            if (scnt_reg == '0)
                            begin
                                pcnt_next = '0;
                                drop_next = 1'b0;
                            end
                            else
                            begin
                                sidx_next  = '0;
                                state_next = S_RRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (p_rdata.cpu == cpu_reg)
                begin
                    pirq_next = p_rdata.irq;
                    pcpu_next = p_rdata.cpu;
                    dur_next  = 64'(time_reg - p_rdata.t);
                    sidx_next = '0;
                    state_next = (scnt_reg == '0) ? S_SNEW : S_SRD;
                end
                else if (pidx_p1 == {1'b0, pcnt_reg})
                begin
                    // no pending entry on this cpu
                    state_next = S_IDLE;
                end
                else
                begin
                    pidx_next  = pidx_p1[PCW-1:0];
                    state_next = S_PRD;
                end
            end
            S_SRD:
            begin
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (s_rdata.irq == pirq_reg)
                begin
                    row_next   = sidx_reg[SAW-1:0];
                    rcpu_next  = s_rdata.cpu;
                    hits_next  = s_rdata.hits;
                    total_next = s_rdata.total;
                    state_next = S_SWR;
                end
                else if (sidx_p1 == {1'b0, scnt_reg})
                begin
                    state_next = S_SNEW;
                end
                else
                begin
                    sidx_next  = sidx_p1[SCW-1:0];
                    state_next = S_SRD;
                end
            end
            S_SNEW:
            begin
                if (scnt_reg == SCW'(STATS_DEPTH))
                begin
                    // pending entry stays in place
                    drop_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next   = scnt_reg[SAW-1:0];
                    scnt_next  = SCW'(scnt_reg + SCW'(1));
                    rcpu_next  = pcpu_reg;
                    hits_next  = '0;
                    total_next = '0;
                    state_next = S_SWR;
                end
            end
            S_SWR:
            begin
                s_we = 1'b1;
                if (pidx_p1 < {1'b0, pcnt_reg})
                begin
                    state_next = S_SHR;
                end
                else
                begin
                    pcnt_next  = PCW'(pcnt_reg - PCW'(1));
                    state_next = S_IDLE;
                end
            end
            S_SHR:
            begin
                p_raddr    = pidx_p1[PAW-1:0];
                state_next = S_SHW;
            end
            S_SHW:
            begin
                // close the gap left by the matched entry
                p_we      = 1'b1;
                p_waddr   = pidx_reg[PAW-1:0];
                p_wdata   = p_rdata;
                pidx_next = pidx_p1[PCW-1:0];
                if (pidx_p2 < {1'b0, pcnt_reg} && pidx_p2 != {1'b0, pcnt_reg} - (PCW+1)'(1)
                    || pidx_p2 + (PCW+1)'(1) < {1'b0, pcnt_reg} + (PCW+1)'(1)
                       && pidx_p2 < {1'b0, pcnt_reg})
                begin
                    state_next = S_SHR;
                end
                else
                begin
                    pcnt_next  = PCW'(pcnt_reg - PCW'(1));
                    state_next = S_IDLE;
                end
            end
            S_RRD:
            begin
                state_next = S_RDAT;
            end
            S_RDAT:
            begin
                rcpu_next  = s_rdata.cpu;
                pirq_next  = s_rdata.irq;
                hits_next  = s_rdata.hits;
                total_next = s_rdata.total;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                div_start = 1'b0;
                if (div_done)
                begin
                    strobe_next = 1'b1;
                    result_next = '{row_cpu: rcpu_reg, row_irq: pirq_reg, freq_hz: div_freq,
                                    total_ns: total_reg, dropped: drop_snap_reg,
                                    last: (sidx_p1 == {1'b0, scnt_reg})};
                    if (sidx_p1 == {1'b0, scnt_reg})
                    begin
                        scnt_next  = '0;
                        pcnt_next  = '0;
                        drop_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sidx_next  = sidx_p1[SCW-1:0];
                        state_next = S_RRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_RDAT)
        begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pcnt_reg      <= '0;
            scnt_reg      <= '0;
            drop_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            win_start_reg <= '0;
            win_end_reg   <= WIN_END_RST;
            win_width_reg <= WIN_WIDTH_RST;
        end
        else
        begin
            state_reg  <= state_next;
            pcnt_reg   <= pcnt_next;
            scnt_reg   <= scnt_next;
            drop_reg   <= drop_next;
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIN_START: win_start_reg <= cfg_data;
                    REG_WIN_END:   win_end_reg   <= cfg_data;
                    REG_WIN_WIDTH: win_width_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        sidx_reg      <= sidx_next;
        drop_snap_reg <= drop_snap_next;
        cpu_reg       <= cpu_next;
        time_reg      <= time_next;
        pirq_reg      <= pirq_next;
        pcpu_reg      <= pcpu_next;
        dur_reg       <= dur_next;
        row_reg       <= row_next;
        rcpu_reg      <= rcpu_next;
        hits_reg      <= hits_next;
        total_reg     <= total_next;
        result_reg    <= result_next;
    end

    a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= PCW'(PENDING_DEPTH))
        else $error("pending count beyond depth");

    a_scnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scnt_reg <= SCW'(STATS_DEPTH))
        else $error("row count beyond depth");

    a_strobe_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == S_RDIV && div_done))
        else $error("result without finished division");

    a_div_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_RDIV)
        else $error("divider finished outside report");

endmodule

// ===== verif/tb.sv =====
module tb;
    import idp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 300;
    localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        item_t   it;
        bit      has_exp;
        result_t exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    item_t       item = '0;
    logic        result_strobe;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WIN_START;
    logic [63:0] cfg_data = '0;

    // predictor state
    logic [63:0] win_start, win_end, win_width;
    pend_t       open_irqs[$];
    stat_t       irq_stats[$];
    bit          drop_seen;

    result_t     report_q[$];
    int          errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned sent_count = 0;
    logic [63:0] cur_time = 64'd1;

    stim_row_t   dir_tab[14];

    irq_duration_profiler_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rate_of(logic [31:0] hits);
        logic [63:0] q;
        if (win_width == 64'd0)
            return 32'hFFFF_FFFF;
        q = (64'(hits) * 64'd1000000000) / win_width;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic void profile_item(input item_t it, ref result_t rows[$]);
        int p, r;
        logic [63:0] dur;
        stat_t s;
        pend_t e;
        if (it.cmd == CMD_ENTRY || it.cmd == CMD_EXIT) begin
            if (!(it.event_time_ns > win_start && it.event_time_ns < win_end))
                return;
            if (it.cmd == CMD_ENTRY) begin
                if (open_irqs.size() >= PENDING_DEPTH_DEF)
                    drop_seen = 1'b1;
                else begin
                    e.cpu = it.cpu_num;
                    e.irq = it.irq_num;
                    e.t = it.event_time_ns;
                    open_irqs.push_back(e);
                end
                return;
            end
            p = -1;
            foreach (open_irqs[i])
                if (p < 0 && open_irqs[i].cpu == it.cpu_num)
                    p = i;
            if (p < 0)
                return;
            dur = it.event_time_ns - open_irqs[p].t;
            r = -1;
            foreach (irq_stats[i])
                if (r < 0 && irq_stats[i].irq == open_irqs[p].irq)
                    r = i;
            if (r < 0) begin
                if (irq_stats.size() >= STATS_DEPTH_DEF) begin
                    drop_seen = 1'b1;
                    return;
                end
                s.irq = open_irqs[p].irq;
                s.cpu = open_irqs[p].cpu;
                s.hits = '0;
                s.total = '0;
                irq_stats.push_back(s);
                r = irq_stats.size() - 1;
            end
            irq_stats[r].total = irq_stats[r].total + dur;
            if (irq_stats[r].hits != 32'hFFFF_FFFF)
                irq_stats[r].hits = irq_stats[r].hits + 32'd1;
            open_irqs.delete(p);
        end else if (it.cmd == CMD_REPORT) begin
            foreach (irq_stats[i])
                rows.push_back('{irq_stats[i].cpu, irq_stats[i].irq,
                                 rate_of(irq_stats[i].hits), irq_stats[i].total,
                                 drop_seen, (i == irq_stats.size() - 1)});
            irq_stats.delete();
            open_irqs.delete();
            drop_seen = 1'b0;
        end
    endfunction

    task automatic send_item(input item_t it, input bit has_exp = 1'b0,
                             input result_t exp = '0, input bit may_idle = 1'b1);
        result_t rows[$];
        if (may_idle && !(sent_count >= 150 && sent_count < 260)
            && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        sent_count++;
        profile_item(it, rows);
        if (has_exp)
            report_q.push_back(exp);
        else
            foreach (rows[i])
                report_q.push_back(rows[i]);
    endtask

    // hold off until every report row is out and the block has gone quiet
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (report_q.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_WIN_START: win_start = val;
            REG_WIN_END:   win_end = val;
            REG_WIN_WIDTH: win_width = val;
            default: ;
        endcase
    endtask

    task automatic set_window(input logic [63:0] ws, input logic [63:0] we,
                              input logic [63:0] ww);
        write_reg(REG_WIN_START, ws);
        write_reg(REG_WIN_END, we);
        write_reg(REG_WIN_WIDTH, ww);
        cfg_valid <= 1'b0;
        cur_time = ws + 64'd1;
    endtask

    function automatic logic [63:0] next_time();
        if ($urandom_range(0, 99) < 8)
            return {$urandom, $urandom};
        cur_time = cur_time + 64'($urandom_range(1, 3000));
        if (!(cur_time > win_start && cur_time < win_end))
            cur_time = win_start + 64'd1;
        return cur_time;
    endfunction

    task automatic random_items(input int n);
        item_t it;
        int roll;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            it.cmd = (roll < 45) ? CMD_ENTRY : (roll < 88) ? CMD_EXIT :
                     (roll < 95) ? CMD_REPORT : 2'd3;
            it.cpu_num = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom_range(0, 255));
            it.irq_num = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 40))
                                                       : 10'($urandom_range(0, 1023));
            it.event_time_ns = next_time();
            send_item(it);
        end
        it = '0;
        it.cmd = CMD_REPORT;
        send_item(it);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp,
                               input logic [63:0] got);
        if (exp !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        result_t exp;
        if (result_strobe) begin
            if (report_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $realtime, result);
                errors++;
            end else begin
                exp = report_q.pop_front();
                check_field("row_cpu", exp.row_cpu, result.row_cpu);
                check_field("row_irq", exp.row_irq, result.row_irq);
                check_field("freq_hz", exp.freq_hz, result.freq_hz);
                check_field("total_ns", exp.total_ns, result.total_ns);
                check_field("dropped", exp.dropped, result.dropped);
                check_field("last", exp.last, result.last);
            end
        end
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge clk) begin
        if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("irq_duration_profiler_unit regression: fail");
            $finish;
        end
    end

    initial begin
        item_t it;
        win_start = '0;
        win_end = WIN_END_RST;
        win_width = WIN_WIDTH_RST;
        drop_seen = 1'b0;

        dir_tab[0]  = '{'{CMD_REPORT, 8'd0, 10'd0, 64'd0}, 1'b0, '0};
        dir_tab[1]  = '{'{CMD_ENTRY, 8'd1, 10'd5, 64'd100}, 1'b0, '0};
        dir_tab[2]  = '{'{CMD_EXIT, 8'd1, 10'd0, 64'd350}, 1'b0, '0};
        dir_tab[3]  = '{'{CMD_REPORT, 8'd0, 10'd0, 64'd0}, 1'b1,
                        '{8'd1, 10'd5, 32'd1, 64'd250, 1'b0, 1'b1}};
        dir_tab[4]  = '{'{2'd3, 8'hFF, 10'h3FF, T_MAX}, 1'b0, '0};
        dir_tab[5]  = '{'{CMD_ENTRY, 8'd255, 10'd1023, 64'd1}, 1'b0, '0};
        dir_tab[6]  = '{'{CMD_ENTRY, 8'd0, 10'd0, T_MAX - 64'd1}, 1'b0, '0};
        // zero stamp sits on the window start, so it is ignored
        dir_tab[7]  = '{'{CMD_EXIT, 8'd0, 10'd0, 64'd0}, 1'b0, '0};
        // duration wraps past the top of the counter
        dir_tab[8]  = '{'{CMD_EXIT, 8'd0, 10'd0, 64'd5}, 1'b0, '0};
        dir_tab[9]  = '{'{CMD_EXIT, 8'd255, 10'd1023, T_MAX - 64'd1}, 1'b0, '0};
        dir_tab[10] = '{'{CMD_EXIT, 8'd7, 10'd3, 64'd10}, 1'b0, '0};
        dir_tab[11] = '{'{CMD_ENTRY, 8'd255, 10'd9, T_MAX}, 1'b0, '0};
        dir_tab[12] = '{'{CMD_EXIT, 8'd255, 10'd9, T_MAX}, 1'b0, '0};
        dir_tab[13] = '{'{CMD_REPORT, 8'd0, 10'd0, 64'd0}, 1'b0, '0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_window(64'd0, T_MAX, WIN_WIDTH_RST);

        foreach (dir_tab[i])
            send_item(dir_tab[i].it, dir_tab[i].has_exp, dir_tab[i].exp);

        // overflow the pending store, then fill the statistics store
        for (int i = 0; i < 33; i++)
            send_item('{CMD_ENTRY, 8'd9, 10'(100 + i), 64'(1000 + i)});
        for (int i = 0; i < 32; i++)
            send_item('{CMD_EXIT, 8'd9, 10'd0, 64'(5000 + 7 * i)});
        send_item('{CMD_ENTRY, 8'd9, 10'd999, 64'd9000});
        send_item('{CMD_EXIT, 8'd9, 10'd0, 64'd9100});
        send_item('{CMD_REPORT, 8'd0, 10'd0, 64'd0});
        drain();

        random_items(60);
        drain();
        set_window(64'd0, T_MAX, 64'd0);
        random_items(45);
        drain();
        set_window(64'd1000, 64'h8000_0000_0000_0000, 64'd1);
        random_items(50);
        drain();
        set_window(T_MAX - 64'd200000, T_MAX, T_MAX);
        random_items(45);
        drain();
        set_window({32'd0, $urandom}, {$urandom | 32'h1, $urandom},
                   {$urandom_range(0, 3), $urandom});
        random_items(60);
        drain();
        // inverted window ignores every entry and exit event
        set_window(T_MAX, 64'd0, WIN_WIDTH_RST);
        random_items(15);
        drain();
        set_window(64'd0, T_MAX, 64'd3);
        random_items(35);
        drain();

        if (errors == 0)
            $display("irq_duration_profiler_unit regression: pass");
        else
            $display("irq_duration_profiler_unit regression: fail");
        $finish;
    end
endmodule

// ===== irq_duration_profiler_unit.f =====
rtl/core/idp_pkg.sv
rtl/core/idp_ram.sv
rtl/core/idp_freq_div.sv
rtl/core/irq_duration_profiler_unit.sv
verif/tb.sv
